[hw/rtl/btff_pkg.sv]
// Shared types and constants for the boundary-tag first-fit allocator.
`default_nettype none
package btff_pkg;

    localparam int unsigned HEAP_WORDS_DEF = 1024;
    localparam logic [31:0] HEAP_MARK      = 32'hCAFEBABE;
    localparam logic [31:0] SPLIT_MIN      = 32'h10;
    localparam logic [13:0] ALIGN_MASK     = 14'h7;

    localparam logic FUNC_ALLOC = 1'b0;
    localparam logic FUNC_FREE  = 1'b1;

    localparam logic STATUS_DONE = 1'b0;
    localparam logic STATUS_OOM  = 1'b1;

    typedef struct packed {
        logic        func;
        logic [12:0] request_size;
        logic [11:0] block_address;
    } btff_in_t;

    typedef struct packed {
        logic        status;
        logic [11:0] payload_address;
    } btff_out_t;

endpackage
`default_nettype wire

[hw/rtl/btff_ram.sv]
// Generic single-write, single-read RAM with registered read data.
`default_nettype none
module btff_ram #(
    parameter int unsigned WIDTH = 32,
    parameter int unsigned DEPTH = 1024
) (
    input  wire logic                     aclk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // Write port and registered read port
    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule
`default_nettype wire

[hw/rtl/boundary_tag_first_fit_allocator.sv]
// Top level: boundary-tag first-fit heap allocator over an internal word RAM.
//
// Input channel s_*: one beat is an allocate (func 0, request_size) or a free
// (func 1, block_address). Result channel m_*: exactly one beat per input beat,
// status 0 done or 1 out of memory, payload_address the payload byte offset of
// an allocated block, else 0. One request is worked at a time; s_ready is high
// only while the sequencer is idle.
// Sequencing: an allocate visits block headers in turn, each visit a RAM read
// plus a next-header add. A free of a valid block makes four tag reads, then the
// tag writes and, when it merges, the merge writes, all through the one RAM write
// port, so the single RAM port pair sets this order; a free whose address is
// ignored is answered without writes.
// Reset: a clearing pass writes every RAM word (prologue, one free block,
// epilogue, zeros), during which s_ready stays low.
// Stall: a result waits in the output register while m_ready is low; the next
// request is accepted meanwhile, and its result waits until the register frees.
`default_nettype none
module boundary_tag_first_fit_allocator
    import btff_pkg::*;
#(
    parameter int unsigned HEAP_WORDS = HEAP_WORDS_DEF
) (
    input  wire logic      aclk,
    input  wire logic      aresetn,
    input  wire logic      s_valid,
    output logic           s_ready,
    input  wire btff_in_t  s_data,
    output logic           m_valid,
    input  wire logic      m_ready,
    output btff_out_t      m_data
);

    localparam int unsigned AW      = $clog2(HEAP_WORDS);
    localparam logic [31:0] LAST    = 32'(HEAP_WORDS - 1);
    localparam logic [31:0] INIT_SZ = 32'(HEAP_WORDS * 4 - 16);

    localparam logic [4:0] S_CLEAR = 5'd0;
    localparam logic [4:0] S_IDLE  = 5'd1;
    localparam logic [4:0] S_A_CHK = 5'd2;
    localparam logic [4:0] S_A_NXT = 5'd3;
    localparam logic [4:0] S_A_S1  = 5'd4;
    localparam logic [4:0] S_A_S2  = 5'd5;
    localparam logic [4:0] S_A_S3  = 5'd6;
    localparam logic [4:0] S_A_S4  = 5'd7;
    localparam logic [4:0] S_A_U1  = 5'd8;
    localparam logic [4:0] S_A_U2  = 5'd9;
    localparam logic [4:0] S_F_0   = 5'd10;
    localparam logic [4:0] S_F_1   = 5'd11;
    localparam logic [4:0] S_F_2   = 5'd12;
    localparam logic [4:0] S_F_3   = 5'd13;
    localparam logic [4:0] S_F_4   = 5'd14;
    localparam logic [4:0] S_F_W1  = 5'd15;
    localparam logic [4:0] S_F_W2  = 5'd16;
    localparam logic [4:0] S_F_W3  = 5'd17;
    localparam logic [4:0] S_F_W4  = 5'd18;
    localparam logic [4:0] S_F_W5  = 5'd19;
    localparam logic [4:0] S_DONE  = 5'd20;

    logic [4:0]    state_reg, state_next;
    logic [AW-1:0] clr_cnt_reg, clr_cnt_next;
    logic [13:0]   size_reg, size_next;
    logic [11:0]   addr_reg, addr_next;
    logic [AW-1:0] cur_reg, cur_next;
    logic [31:0]   nxt_reg, nxt_next;
    logic [31:0]   bs_reg, bs_next;
    logic [31:0]   rest_reg, rest_next;
    logic [31:0]   nb_reg, nb_next;
    logic [AW-1:0] h_reg, h_next;
    logic [AW-1:0] foot_reg, foot_next;
    logic [AW-1:0] p_reg, p_next;
    logic          pvalid_reg, pvalid_next;
    logic          pf_reg, pf_next;
    logic          nf_reg, nf_next;
    logic [31:0]   sh_reg, sh_next;
    logic [31:0]   sp_reg, sp_next;
    logic [31:0]   sn_reg, sn_next;
    logic [31:0]   acc_reg, acc_next;
    logic          res_status_reg, res_status_next;
    logic [11:0]   res_addr_reg, res_addr_next;
    logic          m_valid_reg, m_valid_next;
    btff_out_t     m_data_reg, m_data_next;

    logic [AW-1:0] raddr;
    logic [31:0]   rdata;
    logic          wreq;
    logic [31:0]   widx;
    logic [31:0]   wdata;
    logic          ram_we;

    logic [31:0] size32, cur32, tag, pay32, h32, back, p32, foot32, base32;
    logic [9:0]  wi;

    assign size32 = 32'(size_reg);
    assign cur32  = 32'(cur_reg);
    assign tag    = {rdata[31:1], 1'b0};
    assign pay32  = (cur32 + 32'd1) << 2;
    assign wi     = addr_reg[11:2];
    assign h32    = 32'(wi) - 32'd1;
    assign back   = (rdata >> 2) + 32'd2;
    assign p32    = 32'(h_reg) - back;
    assign foot32 = 32'(h_reg) + (tag >> 2) + 32'd1;
    assign base32 = pf_reg ? 32'(p_reg) : 32'(h_reg);

    btff_ram #(
        .WIDTH (32),
        .DEPTH (HEAP_WORDS)
    ) u_heap (
        .aclk  (aclk),
        .we    (ram_we),
        .waddr (widx[AW-1:0]),
        .wdata (wdata),
        .raddr (raddr),
        .rdata (rdata)
    );

    // Drop writes that fall outside the heap
    assign ram_we  = wreq && (widx < 32'(HEAP_WORDS));
    assign s_ready = (state_reg == S_IDLE);
    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

    // Sequencer and shared index datapath
    always_comb begin
        state_next      = state_reg;
        clr_cnt_next    = clr_cnt_reg;
        size_next       = size_reg;
        addr_next       = addr_reg;
        cur_next        = cur_reg;
        nxt_next        = nxt_reg;
        bs_next         = bs_reg;
        rest_next       = rest_reg;
        nb_next         = nb_reg;
        h_next          = h_reg;
        foot_next       = foot_reg;
        p_next          = p_reg;
        pvalid_next     = pvalid_reg;
        pf_next         = pf_reg;
        nf_next         = nf_reg;
        sh_next         = sh_reg;
        sp_next         = sp_reg;
        sn_next         = sn_reg;
        acc_next        = acc_reg;
        res_status_next = res_status_reg;
        res_addr_next   = res_addr_reg;
        m_valid_next    = m_valid_reg;
        m_data_next     = m_data_reg;
        raddr           = '0;
        wreq            = 1'b0;
        widx            = '0;
        wdata           = '0;

        // Release the output register once the beat is taken
        if (m_valid_reg && m_ready) begin
            m_valid_next = 1'b0;
        end

        unique case (state_reg)
            S_CLEAR: begin
                wreq = 1'b1;
                widx = 32'(clr_cnt_reg);
                if (widx == 32'd0 || widx == LAST) begin
                    wdata = HEAP_MARK;
                end else if (widx == 32'd1 || widx == LAST - 32'd1) begin
                    wdata = INIT_SZ;
                end
                clr_cnt_next = clr_cnt_reg + AW'(1);
                if (widx == LAST) begin
                    state_next = S_IDLE;
                end
            end
            S_IDLE: begin
                raddr = AW'(1);
                if (s_valid) begin
                    size_next = (14'(s_data.request_size) + ALIGN_MASK) & ~ALIGN_MASK;
                    addr_next = s_data.block_address;
                    cur_next  = AW'(1);
                    state_next = (s_data.func == FUNC_FREE) ? S_F_0 : S_A_CHK;
                end
            end
            S_A_CHK: begin
                bs_next  = tag;
                nxt_next = cur32 + (tag >> 2) + 32'd2;
                if (!rdata[0] && tag >= size32) begin
                    state_next = (tag >= size32 + SPLIT_MIN) ? S_A_S1 : S_A_U1;
                end else begin
                    state_next = S_A_NXT;
                end
            end
            S_A_NXT: begin
                raddr = nxt_reg[AW-1:0];
                if (nxt_reg >= LAST) begin
                    res_status_next = STATUS_OOM;
                    res_addr_next   = '0;
                    state_next      = S_DONE;
                end else begin
                    cur_next   = nxt_reg[AW-1:0];
                    state_next = S_A_CHK;
                end
            end
            S_A_S1: begin
                wreq      = 1'b1;
                widx      = cur32;
                wdata     = size32 | 32'd1;
                rest_next = bs_reg - size32 - 32'd8;
                state_next = S_A_S2;
            end
            S_A_S2: begin
                wreq    = 1'b1;
                widx    = cur32 + (size32 >> 2) + 32'd1;
                wdata   = size32 | 32'd1;
                nb_next = widx + 32'd1;
                state_next = S_A_S3;
            end
            S_A_S3: begin
                wreq  = 1'b1;
                widx  = nb_reg;
                wdata = rest_reg;
                state_next = S_A_S4;
            end
            S_A_S4: begin
                wreq  = 1'b1;
                widx  = nb_reg + (rest_reg >> 2) + 32'd1;
                wdata = rest_reg;
                res_status_next = STATUS_DONE;
                res_addr_next   = pay32[11:0];
                state_next      = S_DONE;
            end
            S_A_U1: begin
                wreq  = 1'b1;
                widx  = cur32;
                wdata = bs_reg | 32'd1;
                state_next = S_A_U2;
            end
            S_A_U2: begin
                wreq  = 1'b1;
                widx  = cur32 + (bs_reg >> 2) + 32'd1;
                wdata = bs_reg | 32'd1;
                res_status_next = STATUS_DONE;
                res_addr_next   = pay32[11:0];
                state_next      = S_DONE;
            end
            S_F_0: begin
                raddr           = h32[AW-1:0];
                h_next          = h32[AW-1:0];
                res_status_next = STATUS_DONE;
                res_addr_next   = '0;
                if (wi < 10'd2 || h32 >= LAST) begin
                    state_next = S_DONE;
                end else begin
                    state_next = S_F_1;
                end
            end
            S_F_1: begin
                raddr     = h_reg - AW'(1);
                sh_next   = tag;
                foot_next = foot32[AW-1:0];
                state_next = (foot32 >= LAST) ? S_DONE : S_F_2;
            end
            S_F_2: begin
                raddr       = p32[AW-1:0];
                p_next      = p32[AW-1:0];
                pvalid_next = (h_reg > AW'(1)) && (back <= 32'(h_reg) - 32'd1);
                state_next  = S_F_3;
            end
            S_F_3: begin
                raddr      = foot_reg + AW'(1);
                pf_next    = pvalid_reg && !rdata[0];
                sp_next    = tag;
                state_next = S_F_4;
            end
            S_F_4: begin
                nf_next    = (32'(foot_reg) + 32'd1 < LAST) && !rdata[0];
                sn_next    = tag;
                state_next = S_F_W1;
            end
            S_F_W1: begin
                wreq     = 1'b1;
                widx     = 32'(h_reg);
                wdata    = sh_reg;
                acc_next = sh_reg + (pf_reg ? sp_reg : 32'd0);
                state_next = S_F_W2;
            end
            S_F_W2: begin
                wreq     = 1'b1;
                widx     = 32'(foot_reg);
                wdata    = sh_reg;
                acc_next = acc_reg + (nf_reg ? sn_reg : 32'd0);
                state_next = S_F_W3;
            end
            S_F_W3: begin
                acc_next   = acc_reg + ((pf_reg && nf_reg) ? 32'd16 : 32'd8);
                state_next = (pf_reg || nf_reg) ? S_F_W4 : S_DONE;
            end
            S_F_W4: begin
                wreq  = 1'b1;
                widx  = base32;
                wdata = acc_reg;
                state_next = S_F_W5;
            end
            S_F_W5: begin
                wreq  = 1'b1;
                widx  = base32 + (acc_reg >> 2) + 32'd1;
                wdata = acc_reg;
                state_next = S_DONE;
            end
            S_DONE: begin
                // Hold the result until the output register is free
                if (!m_valid_reg || m_ready) begin
                    m_valid_next                = 1'b1;
                    m_data_next.status          = res_status_reg;
                    m_data_next.payload_address = res_addr_reg;
                    state_next                  = S_IDLE;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    // Control registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= S_CLEAR;
            clr_cnt_reg <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            clr_cnt_reg <= clr_cnt_next;
            m_valid_reg <= m_valid_next;
        end
    end

    // Datapath registers
    always_ff @(posedge aclk) begin
        size_reg       <= size_next;
        addr_reg       <= addr_next;
        cur_reg        <= cur_next;
        nxt_reg        <= nxt_next;
        bs_reg         <= bs_next;
        rest_reg       <= rest_next;
        nb_reg         <= nb_next;
        h_reg          <= h_next;
        foot_reg       <= foot_next;
        p_reg          <= p_next;
        pvalid_reg     <= pvalid_next;
        pf_reg         <= pf_next;
        nf_reg         <= nf_next;
        sh_reg         <= sh_next;
        sp_reg         <= sp_next;
        sn_reg         <= sn_next;
        acc_reg        <= acc_next;
        res_status_reg <= res_status_next;
        res_addr_reg   <= res_addr_next;
        m_data_reg     <= m_data_next;
    end

    // An accepted beat always starts work
    a_accept_starts: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready |=> state_reg != S_IDLE)
        else $error("accepted beat did not start the sequencer");

    // No request is taken during the clearing pass
    a_clear_blocks: assert property (@(posedge aclk) disable iff (!aresetn)
        state_reg == S_CLEAR |-> !s_ready)
        else $error("request accepted during clearing pass");

    // Out of memory never carries an address
    a_oom_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_data.status |-> m_data.payload_address == 12'd0)
        else $error("out-of-memory result with nonzero address");

    // The RAM is written only in clear or tag-update states
    a_write_states: assert property (@(posedge aclk) disable iff (!aresetn)
        ram_we |-> (state_reg == S_CLEAR || state_reg == S_A_S1 ||
                    state_reg == S_A_S2 || state_reg == S_A_S3 ||
                    state_reg == S_A_S4 || state_reg == S_A_U1 ||
                    state_reg == S_A_U2 || state_reg == S_F_W1 ||
                    state_reg == S_F_W2 || state_reg == S_F_W4 ||
                    state_reg == S_F_W5))
        else $error("RAM write outside a write state");

    // A result is loaded only when the output register is free or draining
    a_no_overwrite: assert property (@(posedge aclk) disable iff (!aresetn)
        state_reg == S_DONE && m_valid_reg && !m_ready |=> state_reg == S_DONE)
        else $error("result loaded over a pending beat");

endmodule
`default_nettype wire

[tb/boundary_tag_first_fit_allocator_test.sv]
// Testbench for the boundary-tag first-fit allocator: directed table, then random traffic.
`default_nettype none
module boundary_tag_first_fit_allocator_test;
    import btff_pkg::*;

    localparam int unsigned WORDS = HEAP_WORDS_DEF;
    localparam int unsigned LAST  = WORDS - 1;
    localparam int N_RANDOM       = 1930;

    logic      aclk;
    logic      aresetn;
    logic      s_valid;
    logic      s_ready;
    btff_in_t  s_data;
    logic      m_valid;
    logic      m_ready;
    btff_out_t m_data;

    boundary_tag_first_fit_allocator DUT (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .s_data  (s_data),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_data  (m_data)
    );

    // Shadow heap and queue of pending allocator answers
    logic [31:0] heap_shadow [WORDS];
    btff_out_t   answer_queue [$];
    logic [11:0] live_blocks [$];
    int          mismatch_count;
    bit          rx_quiet;
    bit          hold_off_long;
    bit          hold_off_done;

    // Directed stimulus table; has_answer marks rows whose answer is typed in
    typedef struct {
        logic        func;
        logic [12:0] size;
        logic [11:0] addr;
        bit          has_answer;
        logic        status;
        logic [11:0] paddr;
    } dir_row_t;

    dir_row_t dir_rows [$];

    initial begin
        aclk = 1'b0;
        forever #5 aclk = ~aclk;
    end

    initial begin
        #200_000_000;
        $display("Regression FAIL");
        $finish;
    end

    function automatic logic [31:0] heap_rd(int unsigned i);
        return (i < WORDS) ? heap_shadow[i] : 32'd0;
    endfunction

    function automatic void heap_wr(int unsigned i, logic [31:0] v);
        if (i < WORDS) heap_shadow[i] = v;
    endfunction

    function automatic void sync_footer(int unsigned h);
        logic [31:0] w;
        w = heap_rd(h);
        heap_wr(h + (w & ~32'd1) / 4 + 1, w);
    endfunction

    function automatic void set_size(int unsigned h, logic [31:0] s);
        heap_wr(h, s | (heap_rd(h) & 32'd1));
        sync_footer(h);
    endfunction

    function automatic void set_mark(int unsigned h, bit used);
        heap_wr(h, used ? (heap_rd(h) | 32'd1) : (heap_rd(h) & ~32'd1));
        sync_footer(h);
    endfunction

    function automatic void heap_clear();
        logic [31:0] s;
        s = WORDS * 4 - 16;
        foreach (heap_shadow[i]) heap_shadow[i] = 32'd0;
        heap_shadow[0]        = HEAP_MARK;
        heap_shadow[1]        = s;
        heap_shadow[WORDS-2]  = s;
        heap_shadow[WORDS-1]  = HEAP_MARK;
    endfunction

    // Coalesce a freshly freed block with free neighbours
    function automatic void coalesce(int unsigned h);
        bit pf, nf;
        int unsigned p, n, back;
        logic [31:0] sp, sh, sn;
        pf = 0;
        nf = 0;
        p  = 0;
        if (h > 1) begin
            back = heap_rd(h - 1) / 4 + 2;
            if (back <= h - 1) begin
                p  = h - back;
                pf = (heap_rd(p) & 1) == 0;
            end
        end
        sh = heap_rd(h) & ~32'd1;
        n  = h + sh / 4 + 2;
        if (n < LAST) nf = (heap_rd(n) & 1) == 0;
        sp = heap_rd(p) & ~32'd1;
        sn = heap_rd(n) & ~32'd1;
        if (pf && nf) begin
            set_size(p, sp + sh + sn + 16);
            set_mark(p, 0);
        end else if (pf) begin
            set_size(p, sp + sh + 8);
            set_mark(p, 0);
        end else if (nf) begin
            set_size(h, sh + sn + 8);
            set_mark(h, 0);
        end
    endfunction

    // Compute the allocator answer for one request and update the shadow heap
    function automatic btff_out_t allocate_or_free(btff_in_t req);
        btff_out_t   r;
        int unsigned cur, nxt, size, wi, h;
        logic [31:0] w, bs;
        r.status          = STATUS_DONE;
        r.payload_address = '0;
        if (req.func == FUNC_ALLOC) begin
            size = (32'(req.request_size) + 7) & ~32'h7;
            cur  = 1;
            forever begin
                w  = heap_rd(cur);
                bs = w & ~32'd1;
                if ((w & 1) == 0 && bs >= size) begin
                    if (bs >= size + SPLIT_MIN) begin
                        set_size(cur, size);
                        set_size(cur + size / 4 + 2, bs - size - 8);
                        set_mark(cur + size / 4 + 2, 0);
                    end
                    set_mark(cur, 1);
                    r.payload_address = 12'((cur + 1) * 4);
                    return r;
                end
                nxt = cur + bs / 4 + 2;
                if (nxt >= LAST) break;
                cur = nxt;
            end
            r.status = STATUS_OOM;
            return r;
        end
        wi = req.block_address / 4;
        if (wi < 2) return r;
        h = wi - 1;
        if (h >= LAST) return r;
        if (h + (heap_rd(h) & ~32'd1) / 4 + 1 >= LAST) return r;
        set_mark(h, 0);
        coalesce(h);
        return r;
    endfunction

    // Send one beat, with an optional idle burst ahead of it
    task automatic send_beat(btff_in_t beat, bit may_idle);
        if (may_idle && $urandom_range(0, 3) == 0) begin
            s_valid <= 1'b0;
            repeat ($urandom_range(1, 10)) @(posedge aclk);
        end
        s_valid <= 1'b1;
        s_data  <= beat;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
    endtask

    // Build a random request, mostly frees of live blocks and small allocates
    function automatic btff_in_t random_request();
        btff_in_t q;
        int k, pick;
        q.func          = FUNC_ALLOC;
        q.request_size  = 13'($urandom_range(0, 200));
        q.block_address = 12'($urandom);
        pick = $urandom_range(0, 99);
        if (pick < 45 && live_blocks.size() > 0) begin
            k = $urandom_range(0, live_blocks.size() - 1);
            q.func          = FUNC_FREE;
            q.block_address = live_blocks[k];
            live_blocks.delete(k);
        end else if (pick < 50) begin
            q.func          = FUNC_FREE;
            q.block_address = 12'($urandom);
        end else if (pick < 55) begin
            q.request_size  = 13'($urandom);
        end else if (pick < 60) begin
            q.request_size  = 13'($urandom_range(1000, 4096));
        end
        return q;
    endfunction

    function automatic void push_row(logic f, logic [12:0] s, logic [11:0] a,
                                     bit known, logic st, logic [11:0] pa);
        dir_row_t r;
        r.func = f; r.size = s; r.addr = a;
        r.has_answer = known; r.status = st; r.paddr = pa;
        dir_rows.push_back(r);
    endfunction

    // Stimulus
    initial begin
        btff_in_t  beat;
        btff_out_t ans;
        int        idle_wait;
        aresetn       = 1'b0;
        s_valid       = 1'b0;
        s_data        = '0;
        rx_quiet      = 1'b0;
        hold_off_long = 1'b0;
        heap_clear();
        repeat (3) @(posedge aclk);
        aresetn <= 1'b1;

        push_row(FUNC_ALLOC, 13'd0,    12'd0,    1, STATUS_DONE, 12'd8);
        push_row(FUNC_ALLOC, 13'd8191, 12'd0,    1, STATUS_OOM,  12'd0);
        push_row(FUNC_ALLOC, 13'd4096, 12'd0,    1, STATUS_OOM,  12'd0);
        push_row(FUNC_ALLOC, 13'd1,    12'd0,    0, 0, 0);
        push_row(FUNC_ALLOC, 13'd17,   12'd0,    0, 0, 0);
        push_row(FUNC_ALLOC, 13'd40,   12'd0,    0, 0, 0);
        push_row(FUNC_FREE,  13'd0,    12'd0,    1, STATUS_DONE, 12'd0);
        push_row(FUNC_FREE,  13'd0,    12'd7,    1, STATUS_DONE, 12'd0);
        push_row(FUNC_FREE,  13'd0,    12'd4095, 1, STATUS_DONE, 12'd0);
        push_row(FUNC_FREE,  13'd0,    12'd24,   0, 0, 0);
        push_row(FUNC_FREE,  13'd0,    12'd8,    0, 0, 0);
        push_row(FUNC_FREE,  13'd0,    12'd43,   0, 0, 0);
        push_row(FUNC_ALLOC, 13'd24,   12'd0,    0, 0, 0);
        push_row(FUNC_ALLOC, 13'd4000, 12'd0,    0, 0, 0);
        push_row(FUNC_FREE,  13'd0,    12'd2048, 0, 0, 0);
        push_row(FUNC_FREE,  13'd8191, 12'd16,   0, 0, 0);
        push_row(FUNC_ALLOC, 13'd4072, 12'd0,    0, 0, 0);
        push_row(FUNC_ALLOC, 13'd4064, 12'd0,    0, 0, 0);
        push_row(FUNC_ALLOC, 13'd0,    12'd0,    0, 0, 0);

        // Walk the directed table
        foreach (dir_rows[i]) begin
            beat.func          = dir_rows[i].func;
            beat.request_size  = dir_rows[i].size;
            beat.block_address = dir_rows[i].addr;
            ans = allocate_or_free(beat);
            if (dir_rows[i].has_answer) begin
                ans.status          = dir_rows[i].status;
                ans.payload_address = dir_rows[i].paddr;
            end
            answer_queue.push_back(ans);
            send_beat(beat, 1);
        end
        s_valid <= 1'b0;
        idle_wait = 0;
        while (answer_queue.size() > 0 && idle_wait < 100_000) begin
            @(posedge aclk);
            idle_wait++;
        end
        repeat (40) @(posedge aclk);

        // Restart the shadow from a clean heap by freeing the leftovers is not
        // possible without reset, so keep tracking the live blocks instead
        live_blocks.delete();
        for (int i = 0; i < N_RANDOM; i++) begin
            if (i == 300) hold_off_long = 1'b1;
            if (i == N_RANDOM - 200) rx_quiet = 1'b1;
            beat = random_request();
            ans  = allocate_or_free(beat);
            if (beat.func == FUNC_ALLOC && ans.status == STATUS_DONE)
                live_blocks.push_back(ans.payload_address);
            answer_queue.push_back(ans);
            send_beat(beat, !rx_quiet);
        end
        s_valid <= 1'b0;

        // Drain
        idle_wait = 0;
        while (answer_queue.size() > 0 && idle_wait < 200_000) begin
            @(posedge aclk);
            idle_wait++;
        end
        repeat (100) @(posedge aclk);
        if (mismatch_count == 0 && answer_queue.size() == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

    // Result side: random stalls, one long hold-off while input keeps coming
    initial begin
        m_ready       = 1'b0;
        hold_off_done = 1'b0;
        @(posedge aclk);
        while (!aresetn) @(posedge aclk);
        forever begin
            if (hold_off_long && !hold_off_done) begin
                hold_off_done = 1'b1;
                m_ready <= 1'b0;
                repeat (400) @(posedge aclk);
            end else if (!rx_quiet && $urandom_range(0, 3) == 0) begin
                m_ready <= 1'b0;
                repeat ($urandom_range(1, 10)) @(posedge aclk);
            end
            m_ready <= 1'b1;
            @(posedge aclk);
        end
    end

    // Compare each accepted result beat with the oldest expected answer
    always @(posedge aclk) begin
        btff_out_t want;
        if (aresetn && m_valid && m_ready) begin
            if (answer_queue.size() == 0) begin
                mismatch_count++;
                if (mismatch_count <= 10)
                    $display("Unexpected result beat: status %0d addr %0d",
                             m_data.status, m_data.payload_address);
            end else begin
                want = answer_queue.pop_front();
                if (m_data.status !== want.status ||
                    m_data.payload_address !== want.payload_address) begin
                    mismatch_count++;
                    if (mismatch_count <= 10)
                        $display("Mismatch: expected status %0d addr %0d, got status %0d addr %0d",
                                 want.status, want.payload_address,
                                 m_data.status, m_data.payload_address);
                end
            end
        end
    end

    initial mismatch_count = 0;

endmodule
`default_nettype wire

[sim.f]
hw/rtl/btff_pkg.sv
hw/rtl/btff_ram.sv
hw/rtl/boundary_tag_first_fit_allocator.sv
tb/boundary_tag_first_fit_allocator_test.sv
